// ===== rtl/sipf_pkg.sv =====
// Shared types and constants for the servo instruction packet framer.
// Used by the front, queue, back and top modules; no dependencies.
`default_nettype none

package sipf_pkg;

  localparam logic [1:0] OP_READ      = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_REG_WRITE = 2'd2;
  localparam logic [1:0] OP_ACTION    = 2'd3;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] BCAST_ID      = 8'hFE;
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_REG_WRITE = 8'h04;
  localparam logic [7:0] INS_ACTION    = 8'h05;

  // byte positions inside a packet
  localparam logic [3:0] POS_HDR1   = 4'd1;
  localparam logic [3:0] POS_ID     = 4'd2;
  localparam logic [3:0] POS_LEN    = 4'd3;
  localparam logic [3:0] POS_INS    = 4'd4;
  localparam logic [3:0] POS_PARAM0 = 4'd5;
  localparam logic [3:0] POS_PARAM1 = 4'd6;
  localparam logic [3:0] POS_PARAM2 = 4'd7;

  localparam int QUEUE_DEPTH = 2;

  // one classified command, ready to be serialized
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] ins;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [1:0] np;    // parameter count, 0..3
    logic [7:0] chk;
  } pkt_desc_t;

endpackage

`default_nettype wire

// ===== rtl/sipf_front.sv =====
// Front end: accepts commands and classifies them into packet descriptors.
// Depends on sipf_pkg.
`default_nettype none

module sipf_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [1:0]            op,
  input  wire [7:0]            servo_id,
  input  wire [7:0]            address,
  input  wire [1:0]            write_count,
  input  wire [15:0]           data_word,
  input  wire [7:0]            read_length,
  output logic                 desc_valid,
  input  wire                  desc_ready,
  output sipf_pkg::pkt_desc_t  desc
);
  import sipf_pkg::*;

  pkt_desc_t  desc_next;
  logic [1:0] wc;
  logic [7:0] sum;

  always_comb begin
    desc_next = '0;
    wc = (write_count > 2'd2) ? 2'd2 : write_count;
    case (op)
      OP_READ: begin
        desc_next.id  = servo_id;
        desc_next.ins = INS_READ;
        desc_next.p0  = address;
        desc_next.p1  = read_length;
        desc_next.np  = 2'd2;
      end
      OP_ACTION: begin
        desc_next.id  = BCAST_ID;
        desc_next.ins = INS_ACTION;
        desc_next.np  = 2'd0;
      end
      default: begin
        desc_next.id  = servo_id;
        desc_next.ins = (op == OP_WRITE) ? INS_WRITE : INS_REG_WRITE;
        desc_next.p0  = address;
        desc_next.p1  = (wc >= 2'd1) ? data_word[7:0] : 8'h00;
        desc_next.p2  = (wc >= 2'd2) ? data_word[15:8] : 8'h00;
        desc_next.np  = wc + 2'd1;
      end
    endcase
    desc_next.len = {6'd0, desc_next.np} + 8'd2;
    // unused parameter slots are zero, so they drop out of the sum
    sum = desc_next.id + desc_next.len + desc_next.ins
        + desc_next.p0 + desc_next.p1 + desc_next.p2;
    desc_next.chk = HDR_BYTE - sum;
  end

  assign in_ready = !desc_valid || desc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (in_ready) begin
      desc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc <= desc_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> (desc.len == {6'd0, desc.np} + 8'd2))
    else $error("descriptor length does not match parameter count");

endmodule

`default_nettype wire

// ===== rtl/sipf_queue.sv =====
// Short descriptor queue between front and back ends.
// Depends on sipf_pkg.
`default_nettype none

module sipf_queue #(
  parameter int DEPTH = sipf_pkg::QUEUE_DEPTH
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       wr_valid,
  output logic                      wr_ready,
  input  wire sipf_pkg::pkt_desc_t  wr_desc,
  output logic                      rd_valid,
  input  wire                       rd_ready,
  output sipf_pkg::pkt_desc_t       rd_desc
);
  import sipf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  pkt_desc_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_desc  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_desc;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count above depth");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

// ===== rtl/sipf_back.sv =====
// Back end: serializes one packet descriptor into bytes, one per cycle while out_ready
// allows, into an output register. Depends on sipf_pkg.
`default_nettype none

module sipf_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       desc_valid,
  output logic                      desc_ready,
  input  wire sipf_pkg::pkt_desc_t  desc,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [7:0]                tx_byte,
  output logic                      last
);
  import sipf_pkg::*;

  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       emit;
  logic       is_last;
  logic [7:0] byte_sel;

  assign last_idx = POS_PARAM0 + {2'b00, desc.np};
  assign is_last  = (idx == last_idx);
  assign emit     = desc_valid && (!out_valid || out_ready);
  // the descriptor leaves the queue with its checksum byte
  assign desc_ready = emit && is_last;

  always_comb begin
    if (is_last) begin
      byte_sel = desc.chk;
    end else begin
      case (idx)
        POS_HDR1:   byte_sel = HDR_BYTE;
        POS_ID:     byte_sel = desc.id;
        POS_LEN:    byte_sel = desc.len;
        POS_INS:    byte_sel = desc.ins;
        POS_PARAM0: byte_sel = desc.p0;
        POS_PARAM1: byte_sel = desc.p1;
        POS_PARAM2: byte_sel = desc.p2;
        default:    byte_sel = HDR_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= is_last ? 4'd0 : idx + 4'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_byte <= byte_sel;
      last    <= is_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |-> (idx >= POS_PARAM0 && idx <= 4'd8))
    else $error("packet end at impossible byte position");

  assert property (@(posedge clk) disable iff (rst)
    (desc_valid && idx != 4'd0) |-> (idx <= last_idx))
    else $error("byte index ran past the checksum");

endmodule

`default_nettype wire

// ===== rtl/servo_instruction_packet_framer_core.sv =====
// Top level of the servo instruction packet framer.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
`default_nettype none

// Turns one servo command into a complete instruction packet (FF FF, ID, length,
// instruction, parameters, checksum) delivered one byte per result item; last marks
// the checksum byte. A read gives 8 bytes, a write 7 plus its clamped data count,
// an action 6 (sent to broadcast ID FE). The byte serializer emits one byte per
// cycle unless pop stalls the output; commands are taken back to back into a front
// register and a QDEPTH-entry queue until both fill, while earlier packets drain.
// Each descriptor passes the front register and the queue before the output register.
module servo_instruction_packet_framer_core #(
  parameter int QDEPTH = sipf_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire [1:0]   op,
  input  wire [7:0]   servo_id,
  input  wire [7:0]   address,
  input  wire [1:0]   write_count,
  input  wire [15:0]  data_word,
  input  wire [7:0]   read_length,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  tx_byte,
  output logic        last
);
  import sipf_pkg::*;

  logic      in_ready;
  logic      f_valid;
  logic      f_ready;
  pkt_desc_t f_desc;
  logic      q_valid;
  logic      q_ready;
  pkt_desc_t q_desc;
  logic      out_valid;

  assign full  = !in_ready;
  assign empty = !out_valid;

  sipf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (push),
    .in_ready    (in_ready),
    .op          (op),
    .servo_id    (servo_id),
    .address     (address),
    .write_count (write_count),
    .data_word   (data_word),
    .read_length (read_length),
    .desc_valid  (f_valid),
    .desc_ready  (f_ready),
    .desc        (f_desc)
  );

  sipf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_desc  (f_desc),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_desc  (q_desc)
  );

  sipf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (q_valid),
    .desc_ready (q_ready),
    .desc       (q_desc),
    .out_valid  (out_valid),
    .out_ready  (pop),
    .tx_byte    (tx_byte),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for servo_instruction_packet_framer_core: queued commands in, packet bytes out.
// Depends on sipf_pkg and the RTL top; the expected bytes are computed here and checked in order.
`timescale 1ns / 100ps

module tb;
  import sipf_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_LEN     = 120;
  localparam int TAIL_CYCLES  = 30;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  servo_id;
    logic [7:0]  address;
    logic [1:0]  write_count;
    logic [15:0] data_word;
    logic [7:0]  read_length;
  } servo_cmd_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       last;
  } pkt_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [1:0]  op = '0;
  logic [7:0]  servo_id = '0;
  logic [7:0]  address = '0;
  logic [1:0]  write_count = '0;
  logic [15:0] data_word = '0;
  logic [7:0]  read_length = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  tx_byte;
  logic        last;

  servo_cmd_t cmd_backlog[$];
  pkt_byte_t  expected_bytes[$];
  int         accepted_cnt = 0;
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         hold_cycles = 0;
  bit         hold_done = 1'b0;
  int         tx_idle_pct;
  int         rx_idle_pct;

  servo_instruction_packet_framer_core dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .servo_id    (servo_id),
    .address     (address),
    .write_count (write_count),
    .data_word   (data_word),
    .read_length (read_length),
    .empty       (empty),
    .pop         (pop),
    .tx_byte     (tx_byte),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // idle mix: receiver-heavy, then sender-heavy, then none
  assign tx_idle_pct = (accepted_cnt < 80) ? 38 : (accepted_cnt < 160) ? 50 : 0;
  assign rx_idle_pct = (accepted_cnt < 80) ? 50 : (accepted_cnt < 160) ? 38 : 0;

  function automatic servo_cmd_t mk_cmd(input logic [1:0] o, input logic [7:0] id,
                                        input logic [7:0] addr, input logic [1:0] cnt,
                                        input logic [15:0] data, input logic [7:0] rlen);
    servo_cmd_t c;
    c.op          = o;
    c.servo_id    = id;
    c.address     = addr;
    c.write_count = cnt;
    c.data_word   = data;
    c.read_length = rlen;
    return c;
  endfunction

  function automatic void add_expected(input logic [7:0] b, input logic is_last);
    pkt_byte_t e;
    e.tx_byte = b;
    e.last    = is_last;
    expected_bytes.push_back(e);
  endfunction

  // builds the byte sequence of one instruction packet
  function automatic void frame_packet(input servo_cmd_t c);
    logic [7:0] id;
    logic [7:0] ins;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] params[3];
    int         np;
    int         data_bytes;
    np = 0;
    id = c.servo_id;
    case (c.op)
      OP_READ: begin
        ins = INS_READ;
        params[0] = c.address;
        params[1] = c.read_length;
        np = 2;
      end
      OP_ACTION: begin
        ins = INS_ACTION;
        id = BCAST_ID;
      end
      default: begin
        ins = (c.op == OP_WRITE) ? INS_WRITE : INS_REG_WRITE;
        data_bytes = (c.write_count > 2'd2) ? 2 : int'(c.write_count);
        params[0] = c.address;
        params[1] = c.data_word[7:0];
        params[2] = c.data_word[15:8];
        np = 1 + data_bytes;
      end
    endcase
    len = 8'(np + 2);
    sum = id + len + ins;
    add_expected(HDR_BYTE, 1'b0);
    add_expected(HDR_BYTE, 1'b0);
    add_expected(id, 1'b0);
    add_expected(len, 1'b0);
    add_expected(ins, 1'b0);
    for (int i = 0; i < np; i++) begin
      add_expected(params[i], 1'b0);
      sum = sum + params[i];
    end
    add_expected(8'hFF - sum, 1'b1);
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // driver
  always @(posedge clk) begin : drive_blk
    servo_cmd_t sent;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sent = cmd_backlog.pop_front();
        frame_packet(sent);
        accepted_cnt <= accepted_cnt + 1;
      end
      // a blocked item stays on the ports until taken
      if (!(push && full)) begin
        if (cmd_backlog.size() != 0 &&
            (hold_cycles != 0 || $urandom_range(0, 99) >= tx_idle_pct)) begin
          push        <= 1'b1;
          op          <= cmd_backlog[0].op;
          servo_id    <= cmd_backlog[0].servo_id;
          address     <= cmd_backlog[0].address;
          write_count <= cmd_backlog[0].write_count;
          data_word   <= cmd_backlog[0].data_word;
          read_length <= cmd_backlog[0].read_length;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long receiver stall once, so the block backs up into full
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_cycles <= HOLD_LEN;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : watch_blk
    pkt_byte_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch("unexpected item, tx_byte", tx_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (tx_byte !== want.tx_byte)
            flag_mismatch("tx_byte", tx_byte, want.tx_byte);
          if (last !== want.last)
            flag_mismatch("last", {7'd0, last}, {7'd0, want.last});
        end
      end
      pop <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[servo_instruction_packet_framer_core] ERROR");
      $finish;
    end
  end

  initial begin : stim_blk
    logic [1:0] cnt;
    logic [7:0] id;
    // corners: field extremes, every op, clamped and zero write counts, odd IDs
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'hFE, 8'hFF, 2'd3, 16'hFFFF, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'hFF, 8'hFF, 2'd1, 16'h1234, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'h55, 8'hAA, 2'd2, 16'hA5A5, 8'h55));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 8'h00, 8'h00, 2'd1, 16'h0000, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 8'hFE, 8'hFF, 2'd2, 16'hFFFF, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 8'h01, 8'h1E, 2'd0, 16'hBEEF, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 8'hFF, 8'h20, 2'd3, 16'h1234, 8'h12));
    cmd_backlog.push_back(mk_cmd(OP_REG_WRITE, 8'h00, 8'h00, 2'd1, 16'h00FF, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_REG_WRITE, 8'hFE, 8'hFF, 2'd2, 16'hFF00, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_REG_WRITE, 8'h7F, 8'h80, 2'd0, 16'h5A5A, 8'h33));
    cmd_backlog.push_back(mk_cmd(OP_REG_WRITE, 8'hFF, 8'hFF, 2'd3, 16'hFFFF, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_ACTION, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_ACTION, 8'hFF, 8'hFF, 2'd3, 16'hFFFF, 8'hFF));
    cmd_backlog.push_back(mk_cmd(OP_ACTION, 8'h12, 8'h34, 2'd2, 16'h5678, 8'h9A));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 8'h80, 8'h7F, 2'd2, 16'h8001, 8'h00));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'h01, 8'h01, 2'd0, 16'h0000, 8'h01));
    cmd_backlog.push_back(mk_cmd(OP_ACTION, 8'hFE, 8'h00, 2'd1, 16'h0001, 8'h00));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // write counts outside 1..2 and ID 0xFF are the rarer cases
      cnt = ($urandom_range(0, 99) < 80) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
      id  = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 254)) : 8'($urandom);
      cmd_backlog.push_back(mk_cmd(2'($urandom_range(0, 3)), id, 8'($urandom), cnt,
                                   16'($urandom), 8'($urandom)));
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (cmd_backlog.size() != 0 || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
      $display("[servo_instruction_packet_framer_core] OK");
    end else begin
      $display("[servo_instruction_packet_framer_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sipf_pkg.sv
rtl/sipf_front.sv
rtl/sipf_queue.sv
rtl/sipf_back.sv
rtl/servo_instruction_packet_framer_core.sv
dv/tb.sv
